FILE: rtl/core/clsr_pkg.sv
// clsr_pkg: shared types and constants of the combined LCG shuffle generator.
// Generator primes, multipliers, fold constants, sequencer states, CSR codes.
// No dependencies.
package clsr_pkg;

   // first generator: x * 40014 mod (2^31 - 85)
   localparam logic [30:0] MOD1      = 31'd2147483563;
   localparam logic [15:0] MUL1      = 16'd40014;
   localparam logic [7:0]  FOLD1     = 8'd85;
   // second generator: x * 40692 mod (2^31 - 249)
   localparam logic [30:0] MOD2      = 31'd2147483399;
   localparam logic [15:0] MUL2      = 16'd40692;
   localparam logic [7:0]  FOLD2     = 8'd249;

   localparam logic [30:0] GEN2_INIT = 31'd123456789;
   localparam logic [30:0] MIX_WRAP  = 31'd2147483562;
   localparam int          WARMUP    = 8;

   // register select, taken from paddr[2]
   localparam logic CSR_IDX_LOW  = 1'b0;
   localparam logic CSR_IDX_HIGH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_RED,
      ST_DRAW_MUL,
      ST_DRAW_RED,
      ST_READ,
      ST_MIX
   } clsr_state_type;

   // raw output handed from the core to the scaling pipeline
   typedef struct packed {
      logic        valid;
      logic [30:0] raw;
   } clsr_push_type;

endpackage

FILE: rtl/core/clsr_gen_step.sv
// clsr_gen_step: one step of both multiplicative generators, two lanes.
// Product registered, then folded modulo 2^31 - c with one correction.
// Depends on clsr_pkg.
module clsr_gen_step (
   input  logic        clock,
   input  logic [30:0] x1,
   input  logic [30:0] x2,
   output logic [30:0] y1,
   output logic [30:0] y2
);
   import clsr_pkg::*;

   logic [46:0] prod1_ff;
   logic [46:0] prod2_ff;

   // p = hi * 2^31 + lo, and 2^31 == f (mod modv); hi * f + lo < 2 * modv
   function automatic logic [30:0] fold_mod(input logic [46:0] p,
                                            input logic [30:0] modv,
                                            input logic [7:0]  f);
      logic [31:0] v;
      v = 32'(p[46:31]) * 32'(f) + 32'(p[30:0]);
      if (v >= 32'(modv)) begin
         v = v - 32'(modv);
      end
      return v[30:0];
   endfunction

   // multiply stage
   always_ff @(posedge clock) begin
      prod1_ff <= 47'(x1) * 47'(MUL1);
      prod2_ff <= 47'(x2) * 47'(MUL2);
   end

   // reduction
   assign y1 = fold_mod(prod1_ff, MOD1, FOLD1);
   assign y2 = fold_mod(prod2_ff, MOD2, FOLD2);

endmodule

FILE: rtl/core/clsr_core.sv
// clsr_core: sequencer, generator state and the shuffle table memory.
// Reseed warm-up, slot select, read-modify-write of the table, mixing.
// Depends on clsr_pkg and clsr_gen_step.
module clsr_core #(
   parameter int TABLE_SIZE = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  logic [30:0]            req_seed,
   output logic                   req_stall,
   output clsr_pkg::clsr_push_type push,
   input  logic                   push_ready
);
   import clsr_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_SIZE);
   localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP);
   localparam int MW     = $clog2(TABLE_SIZE) + 2;
   localparam int PW     = 31 + MW;
   localparam logic [30:0]   SLOT_DIV = 31'(32'd1 + 32'(MIX_WRAP) / 32'(TABLE_SIZE));
   localparam logic [MW-1:0] SLOT_M   = MW'(64'h8000_0000 / 64'(SLOT_DIV));

   clsr_state_type state_ff, state_in;

   logic [30:0]       gen1_ff;
   logic [30:0]       gen2_ff;
   logic [30:0]       last_out_ff;
   logic [30:0]       y1;
   logic [30:0]       y2;
   logic [30:0]       seed_eff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MW-1:0]     est_ff;
   logic [MW-1:0]     est_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic [PW-1:0]     est_prod;
   logic [PW-1:0]     rem;
   logic [MW-1:0]     slot_full;

   logic [30:0]           table_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] vld_ff;
   logic [30:0]           rd_data_ff;
   logic                  rd_vld_ff;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic [30:0]           wr_data;

   logic [30:0] old_entry;
   logic [31:0] diff;
   logic [31:0] mixed;

   // generator lanes, always stepping the current state
   clsr_gen_step u_gen_step (
      .clock (clock),
      .x1    (gen1_ff),
      .x2    (gen2_ff),
      .y1    (y1),
      .y2    (y2)
   );

   assign seed_eff = (req_seed == '0) ? 31'd1 : req_seed;

   // slot estimate: last_out * floor(2^31 / div) >> 31, low by at most one
   assign est_prod = PW'(last_out_ff) * PW'(SLOT_M);
   assign est_in   = est_prod[PW-1:31];

   // slot correction and clamp
   always_comb begin
      rem       = PW'(last_out_ff) - PW'(est_ff) * PW'(SLOT_DIV);
      slot_full = est_ff + MW'(rem >= PW'(SLOT_DIV));
      if (slot_full >= MW'(TABLE_SIZE)) begin
         slot_full = MW'(TABLE_SIZE - 1);
      end
      slot_in = slot_full[SLOT_W-1:0];
   end

   // mix: old entry minus second generator, wrapped into 1..MIX_WRAP
   assign old_entry = rd_vld_ff ? rd_data_ff : '0;
   assign diff      = 32'(old_entry) - 32'(gen2_ff);
   assign mixed     = (diff[31] || diff == '0) ? diff + 32'(MIX_WRAP) : diff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_mode ? ST_SEED_MUL : ST_DRAW_RED;
            end
         end
         ST_SEED_MUL: state_in = ST_SEED_RED;
         ST_SEED_RED: state_in = (cnt_ff == '0) ? ST_DRAW_MUL : ST_SEED_MUL;
         ST_DRAW_MUL: state_in = ST_DRAW_RED;
         ST_DRAW_RED: state_in = ST_READ;
         ST_READ:     state_in = ST_MIX;
         ST_MIX: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      push.valid = 1'b0;
      push.raw   = mixed[30:0];
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_data    = gen1_ff;
      unique case (state_ff) inside
         ST_IDLE: req_stall = 1'b0;
         ST_SEED_RED: begin
            wr_en   = (cnt_ff < CNT_W'(TABLE_SIZE));
            wr_addr = cnt_ff[SLOT_W-1:0];
            wr_data = y1;
         end
         ST_MIX: begin
            push.valid = 1'b1;
            wr_en      = push_ready;
         end
         ST_SEED_MUL, ST_DRAW_MUL, ST_DRAW_RED, ST_READ: ;
      endcase
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         gen1_ff     <= 31'd1;
         gen2_ff     <= GEN2_INIT;
         last_out_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_mode) begin
                  gen1_ff <= seed_eff;
                  gen2_ff <= seed_eff;
                  cnt_ff  <= CNT_W'(TABLE_SIZE + WARMUP - 1);
               end
            end
            ST_SEED_RED: begin
               gen1_ff <= y1;
               cnt_ff  <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  last_out_ff <= y1;
               end
            end
            ST_DRAW_RED: begin
               gen1_ff <= y1;
               gen2_ff <= y2;
            end
            ST_MIX: begin
               if (push_ready) begin
                  last_out_ff <= mixed[30:0];
               end
            end
            default: ;
         endcase
      end
   end

   // slot pipeline
   always_ff @(posedge clock) begin
      est_ff <= est_in;
      if (state_ff == ST_DRAW_RED) begin
         slot_ff <= slot_in;
      end
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // shuffle table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[slot_ff];
      rd_vld_ff  <= vld_ff[slot_ff];
   end

endmodule

FILE: rtl/core/clsr_scaler.sv
// clsr_scaler: range scaling pipeline and the result register.
// low + trunc(span * raw / (2^31 - 85)) with split multiply and folded divide.
// Depends on clsr_pkg.
module clsr_scaler (
   input  logic                   clock,
   input  logic                   reset,
   input  clsr_pkg::clsr_push_type push,
   output logic                   push_ready,
   input  logic signed [31:0]     range_low,
   input  logic signed [31:0]     range_high,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [30:0]            rsp_raw_value,
   output logic signed [31:0]     rsp_scaled_value
);
   import clsr_pkg::*;

   logic        advance;
   logic [32:0] span;
   logic [6:0]  vld_ff;
   logic        rsp_valid_ff;

   // per-stage carried fields: raw, low, sign of span
   logic [30:0] raw_ff  [7];
   logic [31:0] low_ff  [7];
   logic        neg_ff  [7];

   logic [31:0] a_mag_ff;
   logic [31:0] b_mag_ff;
   logic [47:0] b_pplo_ff;
   logic [47:0] c_pplo_ff;
   logic [46:0] c_pphi_ff;
   logic [62:0] d_prod_ff;
   logic [31:0] e_h_ff;
   logic [39:0] e_v1_ff;
   logic [31:0] f_v2_ff;
   logic [32:0] f_hs_ff;
   logic [32:0] g_q_ff;
   logic [30:0] rsp_raw_ff;
   logic [31:0] rsp_scaled_ff;

   // whole pipeline holds while the result beat is stalled
   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign push_ready = advance;
   assign span       = {range_high[31], range_high} - {range_low[31], range_low};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[5:0], push.valid};
         rsp_valid_ff <= vld_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // capture: magnitude and sign of the span
         raw_ff[0] <= push.raw;
         low_ff[0] <= range_low;
         neg_ff[0] <= span[32];
         a_mag_ff  <= span[32] ? 32'(~span + 33'd1) : span[31:0];
         // low partial product
         b_mag_ff  <= a_mag_ff;
         b_pplo_ff <= 48'(a_mag_ff) * 48'(raw_ff[0][15:0]);
         // high partial product
         c_pplo_ff <= b_pplo_ff;
         c_pphi_ff <= 47'(b_mag_ff) * 47'(raw_ff[1][30:16]);
         // full product
         d_prod_ff <= 63'(c_pplo_ff) + {c_pphi_ff, 16'b0};
         // first fold: 2^31 == 85
         e_h_ff    <= d_prod_ff[62:31];
         e_v1_ff   <= 40'(d_prod_ff[62:31]) * 40'(FOLD1) + 40'(d_prod_ff[30:0]);
         // second fold
         f_v2_ff   <= 32'(e_v1_ff[39:31]) * 32'(FOLD1) + 32'(e_v1_ff[30:0]);
         f_hs_ff   <= 33'(e_h_ff) + 33'(e_v1_ff[39:31]);
         // last correction
         g_q_ff    <= f_hs_ff + 33'(f_v2_ff >= 32'(MOD1));
         // signed offset from low, modulo 2^32
         rsp_raw_ff    <= raw_ff[6];
         rsp_scaled_ff <= neg_ff[6] ? low_ff[6] - g_q_ff[31:0]
                                    : low_ff[6] + g_q_ff[31:0];
         for (int i = 1; i < 7; i++) begin
            raw_ff[i] <= raw_ff[i-1];
            low_ff[i] <= low_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_scaled_value = rsp_scaled_ff;

endmodule

FILE: rtl/core/combined_lcg_shuffle_rng.sv
// combined_lcg_shuffle_rng: top level, APB-style range registers and wiring.
// Depends on clsr_pkg, clsr_core, clsr_scaler.
//
// Usage:
//  - Request beat (req_valid/req_stall): req_mode 0 draws the next number,
//    req_mode 1 reloads both generators from req_seed (0 taken as 1), warms
//    up and refills the shuffle table, then draws. One response beat each.
//  - Response beat (rsp_valid/rsp_stall): rsp_raw_value in 1..2147483562 and
//    rsp_scaled_value = range_low + trunc(span * raw / 2147483563).
//  - Sequencing: a draw occupies the table sequencer (step both generators,
//    select slot, read, mix and write back); a new request is taken only after
//    the last raw value is handed over. A reseed first runs TABLE_SIZE+8
//    generator steps, warm-up then table refill.
//  - Response path: the scaling pipeline adds 8 register stages after the mix.
//  - A response stall freezes the scaling pipeline; the sequencer keeps
//    going until it needs to hand over the next raw value.
//  - Reset (synchronous): generators at 1 and 123456789, last output 0,
//    table reads as all zero, range_low 0, range_high 2147483563.
//  - Write range registers only while no request is in flight.
module combined_lcg_shuffle_rng #(
   parameter int TABLE_SIZE = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [30:0]        req_seed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_raw_value,
   output logic signed [31:0] rsp_scaled_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import clsr_pkg::*;

   logic signed [31:0] range_low_ff;
   logic signed [31:0] range_high_ff;
   clsr_push_type      push;
   logic               push_ready;

   // range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= 32'sd0;
         range_high_ff <= 32'sd2147483563;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            CSR_IDX_LOW:  range_low_ff  <= pwdata;
            CSR_IDX_HIGH: range_high_ff <= pwdata;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (paddr[2])
         CSR_IDX_LOW:  prdata = $unsigned(range_low_ff);
         CSR_IDX_HIGH: prdata = $unsigned(range_high_ff);
      endcase
   end

   assign pready = 1'b1;

   clsr_core #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_mode   (req_mode),
      .req_seed   (req_seed),
      .req_stall  (req_stall),
      .push       (push),
      .push_ready (push_ready)
   );

   clsr_scaler u_scaler (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .push_ready       (push_ready),
      .range_low        (range_low_ff),
      .range_high       (range_high_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_scaled_value (rsp_scaled_value)
   );

endmodule
